// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define FSTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsta check failed");

// Next-cycle implication, held off while reset is asserted.
`define FSTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsta check failed");

// Next-cycle implication that also covers the reset cycles.
`define FSTA_ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fsta check failed");

`endif

// ===== rtl/core/fsta_pkg.sv =====
package fsta_pkg;

    localparam int HISTORY  = 32;
    localparam int STAGES   = 7;

    localparam int STAGE_W  = 3;                    // event stage field
    localparam int TS_W     = 40;                   // timestamp field
    localparam int ENTRY_W  = 41;                   // ring entry / offsets
    localparam int ROW_W    = $clog2(HISTORY);
    localparam int COL_W    = $clog2(STAGES);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int DEPTH    = HISTORY << COL_W;     // rows padded to 2**COL_W
    localparam int SUM_W    = ENTRY_W + ROW_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_T0    = 6'b000100,
        S_SWEEP = 6'b001000,
        S_DRAIN = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

endpackage

// ===== rtl/core/fsta_if.sv =====
interface fsta_in_if;
    logic                          valid;
    logic                          ready;
    logic [fsta_pkg::STAGE_W-1:0]  stage;
    logic [fsta_pkg::TS_W-1:0]     timestamp;

    modport source (output valid, stage, timestamp, input ready);
    modport sink   (input valid, stage, timestamp, output ready);
endinterface

interface fsta_out_if;
    logic                                valid;
    logic                                ready;
    logic [fsta_pkg::STAGE_W-1:0]        stage_index;
    logic signed [fsta_pkg::ENTRY_W-1:0] average_time;
    logic signed [fsta_pkg::ENTRY_W-1:0] latest_time;
    logic                                last_of_run;

    modport source (output valid, stage_index, average_time, latest_time, last_of_run,
                    input ready);
    modport sink   (input valid, stage_index, average_time, latest_time, last_of_run,
                    output ready);
endinterface

// ===== rtl/core/fsta_ram.sv =====
module fsta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/frame_stage_timing_averager_core.sv =====
// Frame stage timing averager.
// Input channel i_evt: one beat per timestamped event. stage 0 marks a frame
// start, stages 1..STAGES-1 record stage times in the current history row,
// larger stage codes are dropped without effect.
// Output channel o_res: a frame start yields STAGES-1 beats, one per stage,
// carrying the stage's offset from frame start in the row just closed and the
// floor mean of that column over all HISTORY rows; last_of_run marks the
// final stage.
// Timing: a stage event is written in the accept cycle and the block is ready
// again next cycle. A frame start walks every row of each column through the
// single read port of the history RAM: a setup state, then a sweep, drain
// and emit per stage, the emit waiting while o_res stalls. The block takes
// no event while a frame start is being processed.
// Reset: a clearing pass writes zero into all 2**clog2(STAGES) * HISTORY RAM
// words; i_evt.ready stays low until it ends.
// Stall: results sit in an output register; the sweep waits at each result
// until that register is free, nothing is dropped.
module frame_stage_timing_averager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsta_in_if.sink     i_evt,
    fsta_out_if.source  o_res
);

    fsta_pkg::t_state r_state, n_state;

    logic [fsta_pkg::ADDR_W-1:0]  r_clr;
    logic [fsta_pkg::ROW_W-1:0]   r_row;
    logic [fsta_pkg::ROW_W-1:0]   r_f;
    logic [fsta_pkg::COL_W-1:0]   r_col;
    logic [fsta_pkg::TS_W-1:0]    r_stamp;     // start time of the new frame
    logic [fsta_pkg::ENTRY_W-1:0] r_t0;        // start time of the closing row
    logic [fsta_pkg::ENTRY_W-1:0] r_latest;
    logic signed [fsta_pkg::SUM_W-1:0] r_sum;

    // read pipeline tags, aligned with RAM data
    logic r_rd_vld;
    logic r_rd_row;

    // output register
    logic                                r_out_valid;
    logic [fsta_pkg::STAGE_W-1:0]        r_out_stage;
    logic signed [fsta_pkg::ENTRY_W-1:0] r_out_avg;
    logic signed [fsta_pkg::ENTRY_W-1:0] r_out_latest;
    logic                                r_out_last;

    logic                         mem_we;
    logic [fsta_pkg::ADDR_W-1:0]  mem_waddr;
    logic [fsta_pkg::ENTRY_W-1:0] mem_wdata;
    logic [fsta_pkg::ADDR_W-1:0]  mem_raddr;
    logic [fsta_pkg::ENTRY_W-1:0] mem_rdata;

    logic                         evt_acc;
    logic                         evt_in_range;
    logic                         evt_start;
    logic                         out_free;
    logic                         col_last;
    logic                         row_last;
    logic [fsta_pkg::ENTRY_W-1:0] diff;
    logic [fsta_pkg::ENTRY_W-1:0] acc_val;
    logic [fsta_pkg::ROW_W-1:0]   row_next;

    assign i_evt.ready  = (r_state == fsta_pkg::S_IDLE);
    assign evt_acc      = i_evt.valid && i_evt.ready;
    assign evt_in_range = (int'(i_evt.stage) < fsta_pkg::STAGES);
    assign evt_start    = (i_evt.stage == '0);
    assign out_free     = !r_out_valid || o_res.ready;
    assign col_last     = (r_col == fsta_pkg::COL_W'(fsta_pkg::STAGES - 1));
    assign row_last     = (r_f == fsta_pkg::ROW_W'(fsta_pkg::HISTORY - 1));
    assign row_next     = r_row + 1'b1;   // HISTORY is a power of two: wraps

    // closing row's entry becomes its offset from frame start
    assign diff    = mem_rdata - r_t0;
    assign acc_val = r_rd_row ? diff : mem_rdata;

    fsta_ram #(
        .WIDTH (fsta_pkg::ENTRY_W),
        .DEPTH (fsta_pkg::DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // read address: stage-0 entry of the current row on a frame start,
    // otherwise the sweep position
    always_comb begin
        if (r_state == fsta_pkg::S_IDLE) begin
            mem_raddr = {r_row, fsta_pkg::COL_W'(0)};
        end else begin
            mem_raddr = {r_f, r_col};
        end
    end

    // one write source per cycle; the states never overlap
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_row, r_col};
        mem_wdata = diff;
        case (r_state)
            fsta_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            fsta_pkg::S_IDLE: begin
                mem_we    = evt_acc && evt_in_range && !evt_start;
                mem_waddr = {r_row, fsta_pkg::COL_W'(i_evt.stage)};
                mem_wdata = {1'b0, i_evt.timestamp};
            end
            fsta_pkg::S_EMIT: begin
                mem_we    = out_free && col_last;
                mem_waddr = {row_next, fsta_pkg::COL_W'(0)};
                mem_wdata = {1'b0, r_stamp};
            end
            default: begin
                // write back the closing row's offset as it passes
                mem_we = r_rd_vld && r_rd_row;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fsta_pkg::S_CLEAR: begin
                if (&r_clr) n_state = fsta_pkg::S_IDLE;
            end
            fsta_pkg::S_IDLE: begin
                if (evt_acc && evt_in_range && evt_start) n_state = fsta_pkg::S_T0;
            end
            fsta_pkg::S_T0:    n_state = fsta_pkg::S_SWEEP;
            fsta_pkg::S_SWEEP: begin
                if (row_last) n_state = fsta_pkg::S_DRAIN;
            end
            fsta_pkg::S_DRAIN: n_state = fsta_pkg::S_EMIT;
            fsta_pkg::S_EMIT: begin
                if (out_free) n_state = col_last ? fsta_pkg::S_IDLE : fsta_pkg::S_SWEEP;
            end
            default:           n_state = fsta_pkg::S_CLEAR;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsta_pkg::S_CLEAR;
            r_clr       <= '0;
            r_row       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == fsta_pkg::S_SWEEP);
            if (r_state == fsta_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == fsta_pkg::S_EMIT && out_free && col_last) begin
                r_row <= row_next;
            end
            if (r_state == fsta_pkg::S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rd_row <= (r_f == r_row);
        if (r_state == fsta_pkg::S_IDLE && evt_acc) begin
            r_stamp <= i_evt.timestamp;
        end
        if (r_state == fsta_pkg::S_T0) begin
            r_t0  <= mem_rdata;
            r_col <= fsta_pkg::COL_W'(1);
            r_f   <= '0;
            r_sum <= '0;
        end else begin
            if (r_state == fsta_pkg::S_SWEEP) begin
                r_f <= r_f + 1'b1;
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + {{fsta_pkg::ROW_W{acc_val[fsta_pkg::ENTRY_W-1]}}, acc_val};
                if (r_rd_row) r_latest <= diff;
            end
            if (r_state == fsta_pkg::S_EMIT && out_free) begin
                r_col <= r_col + 1'b1;
                r_f   <= '0;
                r_sum <= '0;
            end
        end
        if (r_state == fsta_pkg::S_EMIT && out_free) begin
            r_out_stage  <= fsta_pkg::STAGE_W'(r_col);
            // floor division by HISTORY: drop the low ROW_W bits of the sum
            r_out_avg    <= r_sum[fsta_pkg::SUM_W-1:fsta_pkg::ROW_W];
            r_out_latest <= r_latest;
            r_out_last   <= col_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.stage_index  = r_out_stage;
    assign o_res.average_time = r_out_avg;
    assign o_res.latest_time  = r_out_latest;
    assign o_res.last_of_run  = r_out_last;

endmodule

// ===== rtl/core/fsta_checker.sv =====
`include "assert_macros.svh"

module fsta_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_evt_valid,
    input logic                                i_evt_ready,
    input logic [fsta_pkg::STAGE_W-1:0]        i_evt_stage,
    input logic                                i_res_valid,
    input logic                                i_res_ready,
    input logic [fsta_pkg::STAGE_W-1:0]        i_res_stage_index,
    input logic signed [fsta_pkg::ENTRY_W-1:0] i_res_latest_time,
    input logic                                i_res_last_of_run
);

    logic evt_acc;
    logic res_stall;
    logic start_acc;
    logic res_last;
    logic last_ok;
    logic [fsta_pkg::ENTRY_W+fsta_pkg::STAGE_W-1:0] res_beat;

    assign evt_acc   = i_evt_valid && i_evt_ready;
    assign res_stall = i_res_valid && !i_res_ready;
    assign start_acc = evt_acc && (i_evt_stage == '0);
    assign res_last  = i_res_valid && i_res_last_of_run;
    assign last_ok   = (i_res_stage_index == fsta_pkg::STAGE_W'(fsta_pkg::STAGES - 1));
    assign res_beat  = {i_res_latest_time, i_res_stage_index};

    // a frame start occupies the block
    `FSTA_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start_acc, !i_evt_ready)

    // run end only on the final stage
    `FSTA_ASSERT_IMP(a_last_stage, i_clk, i_rst_n, res_last, last_ok)

    // stage 0 is never reported
    `FSTA_ASSERT_IMP(a_no_stage0, i_clk, i_rst_n, i_res_valid, i_res_stage_index != '0)

    // stalled beat holds
    `FSTA_ASSERT_NXT(a_hold, i_clk, i_rst_n, res_stall, i_res_valid && $stable(res_beat))

    // clearing pass follows reset
    `FSTA_ASSERT_NXT_ALL(a_rst_busy, i_clk, !i_rst_n, !i_evt_ready)

endmodule

bind frame_stage_timing_averager_core fsta_checker u_fsta_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_evt_valid       (i_evt.valid),
    .i_evt_ready       (i_evt.ready),
    .i_evt_stage       (i_evt.stage),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_stage_index (o_res.stage_index),
    .i_res_latest_time (o_res.latest_time),
    .i_res_last_of_run (o_res.last_of_run)
);

// ===== tb/sv/tb_frame_stage_timing_averager_core.sv =====
// Stage events go in one beat at a time. Every frame start brings back one
// statistics beat per stage 1..STAGES-1. A local profile model tracks the
// history ring and predicts each beat. Beats are checked in order against
// the queue of pending statistics.
module tb_frame_stage_timing_averager_core;

    timeunit 1ns;
    timeprecision 1ps;

    // frame start code; codes >= STAGES are dropped by the block
    localparam logic [fsta_pkg::STAGE_W-1:0] STG_FRAME_START = 3'd0;
    localparam logic [fsta_pkg::STAGE_W-1:0] STG_DROPPED     = 3'd7;

    // Receiver hold-off used to back the block up into its input.
    localparam int LONG_HOLD      = 600;
    // Quiet-cycle limit. The longest legal silence is the long hold plus one
    // sweep, or the clearing pass after reset. Several times that.
    localparam int WATCHDOG_LIMIT = 5000;
    // Tail after the last beat: a bit more than one column sweep.
    localparam int TAIL_CYCLES    = 50;

    typedef struct packed {
        logic [fsta_pkg::STAGE_W-1:0]        stage_index;
        logic signed [fsta_pkg::ENTRY_W-1:0] average_time;
        logic signed [fsta_pkg::ENTRY_W-1:0] latest_time;
        logic                                last_of_run;
    } t_stage_stat;

    // One event. Where typed is set, the stats of stage t_stage are the
    // hand-worked values below, not the model's.
    typedef struct {
        logic [fsta_pkg::STAGE_W-1:0]        stage;
        logic [fsta_pkg::TS_W-1:0]           stamp;
        bit                                  typed;
        logic [fsta_pkg::STAGE_W-1:0]        t_stage;
        logic signed [fsta_pkg::ENTRY_W-1:0] t_avg;
        logic signed [fsta_pkg::ENTRY_W-1:0] t_lat;
    } t_evt_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsta_in_if  evt_if ();
    fsta_out_if res_if ();

    frame_stage_timing_averager_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Profile model: the history ring, current row, stats of the last close.
    // ---------------------------------------------------------------------
    logic [fsta_pkg::ENTRY_W-1:0] ring [fsta_pkg::HISTORY][fsta_pkg::STAGES];
    int                           cur_row;
    t_stage_stat                  close_stats [$];    // beats from the latest event
    t_stage_stat                  pending_stats [$];  // beats still owed by the block

    int                           errors      = 0;
    int                           tx_idle_pct = 0;
    int                           rx_idle_pct = 0;
    int                           hold_kicks  = 0;    // bump to start one long hold
    logic [fsta_pkg::TS_W-1:0]    clock_now;          // running time for frame traffic

    // Apply one event to the ring. A frame start closes the current row:
    // every stage column goes relative to the row's start time, and that
    // includes stale entries left from an earlier pass through the ring.
    // Then it takes the floor mean of the column and moves to the next row.
    function automatic void profile_event(input logic [fsta_pkg::STAGE_W-1:0] stg,
                                          input logic [fsta_pkg::TS_W-1:0] ts);
        logic signed [fsta_pkg::SUM_W-1:0] col_sum;
        logic signed [fsta_pkg::SUM_W-1:0] col_mean;
        t_stage_stat                       st;
        close_stats.delete();
        if (stg >= fsta_pkg::STAGES) begin
            return;
        end
        if (stg == STG_FRAME_START) begin
            for (int s = 1; s < fsta_pkg::STAGES; s++) begin
                ring[cur_row][s] = ring[cur_row][s] - ring[cur_row][0];
                col_sum = '0;
                for (int r = 0; r < fsta_pkg::HISTORY; r++) begin
                    col_sum += $signed(ring[r][s]);
                end
                // HISTORY is a power of two: floor divide is a plain >>>
                col_mean          = col_sum >>> fsta_pkg::ROW_W;
                st.stage_index    = fsta_pkg::STAGE_W'(s);
                st.average_time   = col_mean[fsta_pkg::ENTRY_W-1:0];
                st.latest_time    = ring[cur_row][s];
                st.last_of_run    = (s == fsta_pkg::STAGES - 1);
                close_stats.push_back(st);
            end
            cur_row = (cur_row + 1) % fsta_pkg::HISTORY;
        end
        ring[cur_row][stg] = {1'b0, ts};
    endfunction

    function automatic logic [fsta_pkg::TS_W-1:0] rand_stamp();
        return fsta_pkg::TS_W'({$urandom, $urandom});
    endfunction

    // ---------------------------------------------------------------------
    // Event sender. valid stays up across back-to-back beats and only
    // drops for an idle gap or when the stats are drained.
    // ---------------------------------------------------------------------
    task automatic send_event(input t_evt_row row);
        int idx;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            evt_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        evt_if.valid     <= 1'b1;
        evt_if.stage     <= row.stage;
        evt_if.timestamp <= row.stamp;
        do @(posedge i_clk); while (!evt_if.ready);
        profile_event(row.stage, row.stamp);
        if (row.typed) begin
            idx = int'(row.t_stage) - 1;
            close_stats[idx].average_time = row.t_avg;
            close_stats[idx].latest_time  = row.t_lat;
        end
        foreach (close_stats[i]) begin
            pending_stats.push_back(close_stats[i]);
        end
    endtask

    // Stop sending until every owed beat has come back.
    task automatic drain_stats();
        evt_if.valid <= 1'b0;
        while (pending_stats.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random traffic. Most of it is well-formed frames: some stage events
    // at rising times, then a frame start. Mixed in are loose beats with any
    // stage code (dropped codes too) and any timestamp, and now and then a
    // jump of the time base.
    task automatic run_frames(input int n_items);
        int       sent;
        t_evt_row row;
        sent      = 0;
        row.typed = 1'b0;
        row.t_stage = '0;
        row.t_avg   = '0;
        row.t_lat   = '0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                row.stage = fsta_pkg::STAGE_W'($urandom_range(7));
                row.stamp = rand_stamp();
                send_event(row);
                sent++;
            end else begin
                if ($urandom_range(9) == 0) begin
                    clock_now = rand_stamp();
                end
                for (int s = 1; s < fsta_pkg::STAGES; s++) begin
                    if ($urandom_range(1) != 0) begin
                        clock_now += fsta_pkg::TS_W'($urandom_range(4000));
                        row.stage  = fsta_pkg::STAGE_W'(s);
                        row.stamp  = clock_now;
                        send_event(row);
                        sent++;
                    end
                end
                clock_now += fsta_pkg::TS_W'($urandom_range(4000));
                row.stage  = STG_FRAME_START;
                row.stamp  = clock_now;
                send_event(row);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Directed events. Typed stats are easy to work out by hand from reset:
    //   row 1 has stage 6 at max time, so the stage 6 mean is (2^40-1)>>5.
    //   row 3 starts at max time and stage 2 comes at 0. The offset wraps
    //   to -(2^40-1) and the floor mean rounds down to -2^35.
    // ---------------------------------------------------------------------
    t_evt_row directed_rows [21] = '{
        '{STG_FRAME_START, 40'd0,             1'b1, 3'd6, 41'sd0, 41'sd0},
        '{STG_DROPPED,     40'hFF_FFFF_FFFF,  1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd6,            40'hFF_FFFF_FFFF,  1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd1,            40'h20,            1'b0, 3'd0, 41'sd0, 41'sd0},
        '{STG_FRAME_START, 40'd0,             1'b1, 3'd6,
          41'sd34359738367, 41'sd1099511627775},
        '{STG_FRAME_START, 40'hFF_FFFF_FFFF,  1'b1, 3'd6,
          41'sd34359738367, 41'sd0},
        '{3'd2,            40'd0,             1'b0, 3'd0, 41'sd0, 41'sd0},
        '{STG_FRAME_START, 40'd5,             1'b1, 3'd2,
          -41'sd34359738368, -41'sd1099511627775},
        '{3'd3,            40'd10,            1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd4,            40'd20,            1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd5,            40'd30,            1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd1,            40'd1,             1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd2,            40'd2,             1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd6,            40'h80_0000_0000,  1'b0, 3'd0, 41'sd0, 41'sd0},
        '{STG_FRAME_START, 40'd100,           1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd5,            40'd1,             1'b0, 3'd0, 41'sd0, 41'sd0},
        '{STG_FRAME_START, 40'hFF_FFFF_FFFF,  1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd3,            40'h55_5555_5555,  1'b0, 3'd0, 41'sd0, 41'sd0},
        '{3'd4,            40'hAA_AAAA_AAAA,  1'b0, 3'd0, 41'sd0, 41'sd0},
        '{STG_DROPPED,     40'd0,             1'b0, 3'd0, 41'sd0, 41'sd0},
        '{STG_FRAME_START, 40'h12_3456_789A,  1'b0, 3'd0, 41'sd0, 41'sd0}
    };

    // ---------------------------------------------------------------------
    // Result receiver. It stalls at random. When hold_kicks moves, it holds
    // ready low for the long hold.
    // ---------------------------------------------------------------------
    initial begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_kicks != hold_seen) begin
                hold_seen = hold_kicks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Checker: each accepted beat against the oldest pending stats.
    // ---------------------------------------------------------------------
    task automatic check_field(input string what,
                               input logic signed [fsta_pkg::ENTRY_W-1:0] want,
                               input logic signed [fsta_pkg::ENTRY_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stage_stat want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: stage_index expected none got %0d", $realtime,
                         res_if.stage_index);
                errors++;
            end else begin
                want = pending_stats.pop_front();
                check_field("stage_index",
                            fsta_pkg::ENTRY_W'(want.stage_index),
                            fsta_pkg::ENTRY_W'(res_if.stage_index));
                check_field("average_time", want.average_time, res_if.average_time);
                check_field("latest_time",  want.latest_time,  res_if.latest_time);
                check_field("last_of_run",
                            fsta_pkg::ENTRY_W'(want.last_of_run),
                            fsta_pkg::ENTRY_W'(res_if.last_of_run));
            end
        end
    end

    // Watchdog: too long with no beat on either channel means a hang.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("frame_stage_timing_averager_core: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        evt_if.valid     = 1'b0;
        evt_if.stage     = '0;
        evt_if.timestamp = '0;
        foreach (ring[r, s]) begin
            ring[r][s] = '0;
        end
        cur_row   = 0;
        clock_now = rand_stamp();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, back to back. The block's input stays low
        // through the clearing pass.
        foreach (directed_rows[i]) begin
            send_event(directed_rows[i]);
        end
        drain_stats();

        // Phase 1: the sender idles a little, the receiver a lot. It opens
        // with a long receiver hold so that the output backs up and the
        // block stops taking events.
        tx_idle_pct = 28;
        rx_idle_pct = 80;
        hold_kicks++;
        run_frames(50);
        drain_stats();

        // Phase 2: the other way round.
        tx_idle_pct = 80;
        rx_idle_pct = 28;
        run_frames(50);
        drain_stats();

        // Phase 3: full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_frames(45);
        drain_stats();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("frame_stage_timing_averager_core: match");
        end else begin
            $display("frame_stage_timing_averager_core: mismatch");
        end
        $finish;
    end

endmodule
